@@ hdl/gradient_pixel_shader_macros.svh @@
`ifndef GRADIENT_PIXEL_SHADER_MACROS_SVH
`define GRADIENT_PIXEL_SHADER_MACROS_SVH

// property that must hold whenever the precondition is true
`define GPS_ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// property checked in the cycle after the precondition
`define GPS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/gps_pkg.sv @@
package gps_pkg;

	localparam int MAX_STOPS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;

	localparam int PT_W       = 20;
	localparam int SC_W       = 24;
	localparam int D_W        = 21;
	localparam int PROD_W     = 45;
	localparam int OFF_W      = 17;
	localparam int CH_W       = 8;
	localparam int COL_W      = 32;
	localparam int STOP_IDX_W = 4;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MAG_W      = 31;
	localparam int SQ_W       = 62;
	localparam int SUM_W      = 63;
	localparam int RT_W       = 64;
	localparam int ROOT_ITER  = 32;
	localparam int ROOT_W     = 32;
	localparam int NUM_W      = 17;
	localparam int BLEND_W    = 25;
	localparam int DIVN_W     = 27;
	localparam int DIVD_W     = 18;
	localparam int QUO_W      = 8;
	localparam int CHANNELS   = 4;

	localparam longint SAT_LIM = 64'd1 << 30;

	typedef enum logic {
		MODE_STOP   = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

	typedef enum logic {
		KIND_LINEAR = 1'b0,
		KIND_RADIAL = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		EXT_CLAMP  = 2'd0,
		EXT_REPEAT = 2'd1,
		EXT_MIRROR = 2'd2
	} ext_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KIND     = 3'd0,
		CFG_EXTEND   = 3'd1,
		CFG_COUNT    = 3'd2,
		CFG_ORIGIN_X = 3'd3,
		CFG_ORIGIN_Y = 3'd4,
		CFG_SCALE_X  = 3'd5,
		CFG_SCALE_Y  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic adv;
		logic vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic [STOP_IDX_W-1:0] idx;
		logic [OFF_W-1:0]      offset;
		logic [COL_W-1:0]      colour;
	} stop_wr_t;

endpackage

@@ hdl/gps_if.sv @@
interface gps_in_if;
	import gps_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic signed [PT_W-1:0]  point_x;
	logic signed [PT_W-1:0]  point_y;
	logic [STOP_IDX_W-1:0]   stop_index;
	logic [OFF_W-1:0]        stop_offset;
	logic [CH_W-1:0]         stop_red;
	logic [CH_W-1:0]         stop_green;
	logic [CH_W-1:0]         stop_blue;
	logic [CH_W-1:0]         stop_alpha;

	modport source (
		output valid, mode, point_x, point_y, stop_index, stop_offset,
		output stop_red, stop_green, stop_blue, stop_alpha,
		input  ready
	);
	modport sink (
		input  valid, mode, point_x, point_y, stop_index, stop_offset,
		input  stop_red, stop_green, stop_blue, stop_alpha,
		output ready
	);
endinterface

interface gps_out_if;
	import gps_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic [CH_W-1:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

@@ hdl/gps_sqrt_pipe.sv @@
module gps_sqrt_pipe #(
	parameter int SB_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gps_pkg::pipe_ctl_t        ctl,
	input  logic [gps_pkg::RT_W-1:0]  value,
	input  logic [SB_W-1:0]           sb_in,
	output logic                      vld,
	output logic [gps_pkg::ROOT_W-1:0] root,
	output logic [SB_W-1:0]           sb_out
);
	import gps_pkg::*;

	logic [RT_W-1:0] rem_s  [ROOT_ITER+1];
	logic [RT_W-1:0] rt_s   [ROOT_ITER+1];
	logic            vld_s  [ROOT_ITER+1];
	logic [SB_W-1:0] sb_s   [ROOT_ITER+1];

	assign rem_s[0] = value;
	assign rt_s[0]  = '0;
	assign vld_s[0] = ctl.vld;
	assign sb_s[0]  = sb_in;

	for (genvar k = 0; k < ROOT_ITER; k++) begin : g_step
		localparam logic [RT_W-1:0] BIT = RT_W'(1) << (2 * (ROOT_ITER - 1 - k));
		logic [RT_W-1:0] trial;
		logic [RT_W-1:0] rem_nx;
		logic [RT_W-1:0] rt_nx;

		always_comb begin
			trial = rt_s[k] + BIT;
			if (rem_s[k] >= trial) begin
				rem_nx = rem_s[k] - trial;
				rt_nx  = (rt_s[k] >> 1) + BIT;
			end else begin
				rem_nx = rem_s[k];
				rt_nx  = rt_s[k] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[k+1] <= rem_nx;
				rt_s[k+1]  <= rt_nx;
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign vld    = vld_s[ROOT_ITER];
	assign root   = rt_s[ROOT_ITER][ROOT_W-1:0];
	assign sb_out = sb_s[ROOT_ITER];
endmodule

@@ hdl/gps_div_pipe.sv @@
module gps_div_pipe #(
	parameter int SB_W = 1
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  gps_pkg::pipe_ctl_t                              ctl,
	input  logic [gps_pkg::CHANNELS-1:0][gps_pkg::DIVN_W-1:0] num,
	input  logic [gps_pkg::DIVD_W-1:0]                      den,
	input  logic [SB_W-1:0]                                 sb_in,
	output logic                                            vld,
	output logic [gps_pkg::CHANNELS-1:0][gps_pkg::QUO_W-1:0]  quo,
	output logic [SB_W-1:0]                                 sb_out
);
	import gps_pkg::*;

	logic [CHANNELS-1:0][DIVN_W-1:0] rem_s [QUO_W+1];
	logic [CHANNELS-1:0][QUO_W-1:0]  quo_s [QUO_W+1];
	logic [DIVD_W-1:0]               den_s [QUO_W+1];
	logic                            vld_s [QUO_W+1];
	logic [SB_W-1:0]                 sb_s  [QUO_W+1];

	assign rem_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign vld_s[0] = ctl.vld;
	assign sb_s[0]  = sb_in;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int J = QUO_W - 1 - k;
		logic [DIVN_W-1:0]               dsh;
		logic [CHANNELS-1:0][DIVN_W-1:0] rem_nx;
		logic [CHANNELS-1:0][QUO_W-1:0]  quo_nx;

		always_comb begin
			dsh = DIVN_W'(den_s[k]) << J;
			for (int c = 0; c < CHANNELS; c++) begin
				if (rem_s[k][c] >= dsh) begin
					rem_nx[c] = rem_s[k][c] - dsh;
					quo_nx[c] = quo_s[k][c] | (QUO_W'(1) << J);
				end else begin
					rem_nx[c] = rem_s[k][c];
					quo_nx[c] = quo_s[k][c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[k+1] <= rem_nx;
				quo_s[k+1] <= quo_nx;
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign vld    = vld_s[QUO_W];
	assign quo    = quo_s[QUO_W];
	assign sb_out = sb_s[QUO_W];
endmodule

@@ hdl/gradient_pixel_shader.sv @@
// channel    dir  payload
// item_in    in   mode, point_x/y, stop_index, stop_offset, stop rgba
// item_out   out  out_red, out_green, out_blue, out_alpha
// cfg_*      in   register index and data, write on cfg_wr_en
// one item enters per cycle unless a stalled output holds the pipeline
// a sample passes the stage registers, the 32-step square root pipe and the 8-step divider
// stop items update the table in pipeline order and give no result
// a stalled output freezes the whole pipeline; nothing is dropped
// reset clears valid bits and sets config registers to defaults; payload and the stop table have no reset
module gradient_pixel_shader #(
	parameter int MAX_STOPS     = gps_pkg::MAX_STOPS_DEF,
	parameter int FRACTION_BITS = gps_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gps_pkg::CFG_DATA_W-1:0]  cfg_data,
	gps_in_if.sink                          item_in,
	gps_out_if.source                       item_out
);
	import gps_pkg::*;
	`include "gradient_pixel_shader_macros.svh"

	localparam int FB  = FRACTION_BITS;
	localparam int PW  = FB + 1;
	localparam int TW  = (46 - FB > 33) ? 46 - FB : 33;
	localparam int CW  = (PW > OFF_W) ? PW : OFF_W;
	localparam int IW  = $clog2(MAX_STOPS);
	localparam int NW  = $clog2(MAX_STOPS + 1);
	localparam int SQ_SB_W  = 1 + TW + $bits(stop_wr_t);
	localparam int DIV_SB_W = 1 + COL_W;
	localparam logic signed [TW-1:0]     ONE_T = TW'(64'd1 << FB);
	localparam logic [PW-1:0]            ONE_P = PW'(64'd1 << FB);
	localparam logic [FB+1:0]            TWO_P = (FB+2)'(64'd1 << (FB + 1));
	localparam logic signed [PROD_W-1:0] LIM_P = PROD_W'(SAT_LIM);

	function automatic logic [MAG_W-1:0] sat_mag(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] s;
		s = v;
		if (s > LIM_P) s = LIM_P;
		if (s < -LIM_P) s = -LIM_P;
		return (s < 0) ? MAG_W'(-s) : MAG_W'(s);
	endfunction

	// configuration
	logic                     kind_q;
	logic [1:0]               ext_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PT_W-1:0]   orig_x_q, orig_y_q;
	logic signed [SC_W-1:0]   scl_x_q, scl_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_LINEAR;
			ext_q    <= EXT_CLAMP;
			cnt_q    <= CNT_W'(2);
			orig_x_q <= PT_W'(32768);
			orig_y_q <= '0;
			scl_x_q  <= '0;
			scl_y_q  <= SC_W'(65536);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KIND:     kind_q   <= cfg_data[0];
				CFG_EXTEND:   ext_q    <= cfg_data[1:0];
				CFG_COUNT:    cnt_q    <= cfg_data[CNT_W-1:0];
				CFG_ORIGIN_X: orig_x_q <= cfg_data[PT_W-1:0];
				CFG_ORIGIN_Y: orig_y_q <= cfg_data[PT_W-1:0];
				CFG_SCALE_X:  scl_x_q  <= cfg_data[SC_W-1:0];
				CFG_SCALE_Y:  scl_y_q  <= cfg_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	logic [NW-1:0]        nsat;
	logic [MAX_STOPS-1:0] is_last;

	always_comb begin
		nsat = (int'(cnt_q) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(cnt_q);
		for (int i = 0; i < MAX_STOPS; i++) begin
			is_last[i] = (NW'(i + 1) == nsat);
		end
	end

	// pipeline control
	logic      out_v_q;
	logic      adv;
	pipe_ctl_t sq_ctl, div_ctl;

	assign adv           = !out_v_q || item_out.ready;
	assign item_in.ready = adv;

	// stage registers
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic                     smp_s1, smp_s2, smp_s3, smp_s4, smp_s5, smp_s6, smp_s7;
	stop_wr_t                 wr_s1, wr_s2, wr_s3, wr_s4, wr_s5, wr_s6, wr_s7;
	logic signed [PT_W-1:0]   px_s1, py_s1;
	logic signed [D_W-1:0]    dx_s2, dy_s2;
	logic signed [PROD_W-1:0] prx_s3, pry_s3;
	logic signed [TW-1:0]     tl_s4, tl_s5, tl_s6;
	logic [MAG_W-1:0]         mx_s4, my_s4;
	logic [SQ_W-1:0]          sqx_s5, sqy_s5;
	logic [SUM_W-1:0]         sum_s6;
	logic [PW-1:0]            pos_s7, pos_s8;
	logic [MAX_STOPS-1:0]     le_s8;
	logic                     gel_s8;
	logic                     direct_s9, direct_s10;
	logic [COL_W-1:0]         dcol_s9, dcol_s10, c0_s9, c1_s9;
	logic [NUM_W-1:0]         num_s9, den_s9;
	logic [CHANNELS-1:0][DIVN_W-1:0] nn_s10;
	logic [DIVD_W-1:0]        dd_s10;
	logic [COL_W-1:0]         out_col_q;

	logic [OFF_W-1:0] pos_tab [MAX_STOPS];
	logic [COL_W-1:0] col_tab [MAX_STOPS];

	// root pipe between stage 6 and stage 7
	logic                  sq_vld;
	logic [ROOT_W-1:0]     sq_root;
	logic [SQ_SB_W-1:0]    sq_sb;
	logic                  sq_smp;
	logic signed [TW-1:0]  sq_tl;
	stop_wr_t              sq_wr;

	assign sq_ctl = '{adv: adv, vld: v_s6};

	gps_sqrt_pipe #(.SB_W(SQ_SB_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.value  (RT_W'(sum_s6)),
		.sb_in  ({smp_s6, tl_s6, wr_s6}),
		.vld    (sq_vld),
		.root   (sq_root),
		.sb_out (sq_sb)
	);

	assign {sq_smp, sq_tl, sq_wr} = sq_sb;

	// combinational work per stage
	logic signed [PROD_W:0]   lin_sum;
	logic signed [TW-1:0]     t_sel, t_abs;
	logic [PW-1:0]            q_mod;
	logic [PW-1:0]            pos_nx;
	logic [MAX_STOPS-1:0]     le_nx;
	logic                     gel_nx;

	always_comb begin
		lin_sum = (PROD_W+1)'(prx_s3) + (PROD_W+1)'(pry_s3);
	end

	always_comb begin
		t_sel  = (kind_q == KIND_RADIAL) ? TW'(sq_root) : sq_tl;
		t_abs  = (t_sel < 0) ? -t_sel : t_sel;
		q_mod  = t_abs[FB:0];
		pos_nx = '0;
		if (t_sel >= 0 && t_sel <= ONE_T) begin
			pos_nx = PW'(t_sel);
		end else begin
			case (ext_q)
				EXT_REPEAT: pos_nx = PW'(t_sel[FB-1:0]);
				EXT_MIRROR: pos_nx = (q_mod > ONE_P) ? PW'(TWO_P - (FB+2)'(q_mod)) : q_mod;
				default:    pos_nx = (t_sel < 0) ? '0 : ONE_P;
			endcase
		end
	end

	always_comb begin
		gel_nx = 1'b0;
		for (int i = 0; i < MAX_STOPS; i++) begin
			le_nx[i] = CW'(pos_s7) <= CW'(pos_tab[i]);
			gel_nx   = gel_nx | (is_last[i] && (CW'(pos_s7) >= CW'(pos_tab[i])));
		end
	end

	logic [MAX_STOPS-1:0] hit;
	logic                 seen;
	logic [OFF_W-1:0]     p0, p1;
	logic [COL_W-1:0]     c0, c1, clast;
	logic                 direct_nx;
	logic [COL_W-1:0]     dcol_nx;

	always_comb begin
		seen  = 1'b0;
		hit   = '0;
		p0    = '0;
		p1    = '0;
		c0    = '0;
		c1    = '0;
		clast = '0;
		for (int i = 1; i < MAX_STOPS; i++) begin
			hit[i] = le_s8[i] && (NW'(i) < nsat) && !seen;
			seen   = seen | hit[i];
		end
		for (int i = 0; i < MAX_STOPS; i++) begin
			clast = clast | (is_last[i] ? col_tab[i] : '0);
			if (i > 0) begin
				p0 = p0 | (hit[i] ? pos_tab[i-1] : '0);
				c0 = c0 | (hit[i] ? col_tab[i-1] : '0);
			end
			p1 = p1 | (hit[i] ? pos_tab[i] : '0);
			c1 = c1 | (hit[i] ? col_tab[i] : '0);
		end
		direct_nx = 1'b1;
		if (nsat == '0) begin
			dcol_nx = '0;
		end else if (le_s8[0]) begin
			dcol_nx = col_tab[0];
		end else if (gel_s8 || !seen) begin
			dcol_nx = clast;
		end else if (p1 <= p0) begin
			dcol_nx = c1;
		end else begin
			dcol_nx   = c1;
			direct_nx = 1'b0;
		end
	end

	logic [CHANNELS-1:0][DIVN_W-1:0] nn_nx;
	logic [BLEND_W-1:0]              mix;

	always_comb begin
		nn_nx = '0;
		mix   = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			mix = BLEND_W'(c0_s9[c*CH_W +: CH_W]) * BLEND_W'(den_s9 - num_s9)
				+ BLEND_W'(c1_s9[c*CH_W +: CH_W]) * BLEND_W'(num_s9);
			nn_nx[c] = DIVN_W'({mix, 1'b0}) + DIVN_W'(den_s9);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= item_in.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= sq_vld;
			v_s8  <= v_s7 && smp_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1 <= (item_in.mode == MODE_SAMPLE);
			px_s1  <= item_in.point_x;
			py_s1  <= item_in.point_y;
			wr_s1  <= '{idx: item_in.stop_index, offset: item_in.stop_offset,
				colour: {item_in.stop_alpha, item_in.stop_blue,
					item_in.stop_green, item_in.stop_red}};

			smp_s2 <= smp_s1;
			wr_s2  <= wr_s1;
			dx_s2  <= D_W'(px_s1) - D_W'(orig_x_q);
			dy_s2  <= D_W'(py_s1) - D_W'(orig_y_q);

			smp_s3 <= smp_s2;
			wr_s3  <= wr_s2;
			prx_s3 <= PROD_W'(dx_s2) * PROD_W'(scl_x_q);
			pry_s3 <= PROD_W'(dy_s2) * PROD_W'(scl_y_q);

			smp_s4 <= smp_s3;
			wr_s4  <= wr_s3;
			tl_s4  <= TW'(lin_sum >>> FB);
			mx_s4  <= sat_mag(prx_s3 >>> FB);
			my_s4  <= sat_mag(pry_s3 >>> FB);

			smp_s5 <= smp_s4;
			wr_s5  <= wr_s4;
			tl_s5  <= tl_s4;
			sqx_s5 <= SQ_W'(mx_s4) * SQ_W'(mx_s4);
			sqy_s5 <= SQ_W'(my_s4) * SQ_W'(my_s4);

			smp_s6 <= smp_s5;
			wr_s6  <= wr_s5;
			tl_s6  <= tl_s5;
			sum_s6 <= SUM_W'(sqx_s5) + SUM_W'(sqy_s5);

			smp_s7 <= sq_smp;
			wr_s7  <= sq_wr;
			pos_s7 <= pos_nx;

			pos_s8 <= pos_s7;
			le_s8  <= le_nx;
			gel_s8 <= gel_nx;

			direct_s9 <= direct_nx;
			dcol_s9   <= dcol_nx;
			c0_s9     <= c0;
			c1_s9     <= c1;
			num_s9    <= NUM_W'(CW'(pos_s8) - CW'(p0));
			den_s9    <= NUM_W'(p1 - p0);

			direct_s10 <= direct_s9;
			dcol_s10   <= dcol_s9;
			nn_s10     <= nn_nx;
			dd_s10     <= {den_s9, 1'b0};
		end
	end

	// stop table, written in pipeline order
	always_ff @(posedge clk) begin
		if (adv && v_s7 && !smp_s7 && int'(wr_s7.idx) < MAX_STOPS) begin
			pos_tab[IW'(wr_s7.idx)] <= wr_s7.offset;
			col_tab[IW'(wr_s7.idx)] <= wr_s7.colour;
		end
	end

	// rounding divider
	logic                            div_vld;
	logic [CHANNELS-1:0][QUO_W-1:0]  div_quo;
	logic [DIV_SB_W-1:0]             div_sb;

	assign div_ctl = '{adv: adv, vld: v_s10};

	gps_div_pipe #(.SB_W(DIV_SB_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (nn_s10),
		.den    (dd_s10),
		.sb_in  ({direct_s10, dcol_s10}),
		.vld    (div_vld),
		.quo    (div_quo),
		.sb_out (div_sb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_col_q <= div_sb[COL_W] ? div_sb[COL_W-1:0] : div_quo;
		end
	end

	assign item_out.valid     = out_v_q;
	assign item_out.out_red   = out_col_q[0*CH_W +: CH_W];
	assign item_out.out_green = out_col_q[1*CH_W +: CH_W];
	assign item_out.out_blue  = out_col_q[2*CH_W +: CH_W];
	assign item_out.out_alpha = out_col_q[3*CH_W +: CH_W];

	`GPS_ASSERT_IMPLY(a_pos_range, v_s8, pos_s8 <= ONE_P, "extended parameter above one")
	`GPS_ASSERT_NEXT(a_blend_span, v_s8 && !direct_nx && adv,
		num_s9 != '0 && num_s9 <= den_s9, "blend offset outside its span")
endmodule
